/* rtl/alt_pkg.sv */
// Package for the address learning table.
// Holds the field widths, the result status codes and the stored entry type.
// No dependencies.
package alt_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned MAC_W = 48;

  typedef enum logic {
    FUNC_LEARN   = 1'b0,
    FUNC_RESOLVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_PRESENT  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } entry_t;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

endpackage

/* rtl/address_learning_table.sv */
// Address learning table: maps node addresses to MAC addresses.
// Entries live in one synchronous entry memory scanned one entry per cycle.
// Depends on alt_pkg.
//
//  channel   signals                                   direction  handshake
//  request   start_i, func_i, node_addr_i, mac_in_i    in         start_i && !busy_o
//  result    done_o, mac_out_o, status_o               out        done_o, one cycle
//
// An item compares the valid entries in turn, stopping at the first match
// or after the last filled entry; with an empty table the result is decided
// as the item is accepted. The scan is paced by the single read port of the
// entry memory. Reset empties the table by clearing the fill count; the
// memory is not cleared. The result is shown for one cycle with done_o and
// cannot be held off; a new item may start in that same cycle.
module address_learning_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      func_i,
  input  logic [alt_pkg::KEY_W-1:0] node_addr_i,
  input  logic [alt_pkg::MAC_W-1:0] mac_in_i,
  output logic                      done_o,
  output logic [alt_pkg::MAC_W-1:0] mac_out_o,
  output logic [1:0]                status_o
);
  import alt_pkg::*;

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  entry_t entry_mem [TABLE_ENTRIES];

  logic [0:0]       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             func_q;
  logic [KEY_W-1:0] key_q;
  logic [MAC_W-1:0] mac_q;
  entry_t           rd_q;
  logic [IdxW-1:0]  raddr;
  logic             accept;
  logic             fin;
  logic             fin_func;
  logic             fin_found;
  logic [MAC_W-1:0] fin_hit_mac;
  logic [KEY_W-1:0] fin_key;
  logic [MAC_W-1:0] fin_mac;
  logic             full;
  logic             match;
  logic             last;
  logic             wr_en;
  logic             done_q, done_d;
  logic [MAC_W-1:0] mac_out_q, mac_out_d;
  status_e          status_q, status_d;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (fill_q == FillW'(TABLE_ENTRIES));
  assign match  = (rd_q.key == key_q);
  assign last   = ((FillW'(cmp_idx_q) + FillW'(1)) == fill_q);

  always_comb begin
    state_d     = state_q;
    cmp_idx_d   = cmp_idx_q;
    raddr       = '0;
    fin         = 1'b0;
    fin_func    = func_q;
    fin_found   = 1'b0;
    fin_hit_mac = rd_q.mac;
    fin_key     = key_q;
    fin_mac     = mac_q;
    case (state_q)
      S_IDLE: begin
        cmp_idx_d = '0;
        if (accept) begin
          if (fill_q == '0) begin
            fin      = 1'b1;
            fin_func = func_i;
            fin_key  = node_addr_i;
            fin_mac  = mac_in_i;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        raddr = cmp_idx_q + IdxW'(1);
        if (match || last) begin
          fin       = 1'b1;
          fin_found = match;
          state_d   = S_IDLE;
        end else begin
          cmp_idx_d = cmp_idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    done_d    = fin;
    mac_out_d = '0;
    status_d  = ST_PRESENT;
    wr_en     = 1'b0;
    fill_d    = fill_q;
    if (fin) begin
      if (fin_func == FUNC_RESOLVE) begin
        if (fin_found) begin
          mac_out_d = fin_hit_mac;
          status_d  = ST_PRESENT;
        end else begin
          mac_out_d = MAC_BCAST;
          status_d  = ST_MISS;
        end
      end else if (fin_found) begin
        status_d = ST_PRESENT;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_INSERTED;
        wr_en    = 1'b1;
        fill_d   = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[fill_q[IdxW-1:0]] <= '{key: fin_key, mac: fin_mac};
    end
    rd_q <= entry_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cmp_idx_q <= cmp_idx_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= node_addr_i;
      mac_q  <= mac_in_i;
    end
    mac_out_q <= mac_out_d;
    status_q  <= status_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign mac_out_o = mac_out_q;
  assign status_o  = status_q;

endmodule

/* rtl/alt_checker.sv */
// Port-level checks for the address learning table, attached by bind.
// Depends on alt_pkg and address_learning_table.
module alt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [alt_pkg::MAC_W-1:0] mac_out_o,
  input logic [1:0]                status_o
);
  import alt_pkg::*;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted item neither in work nor done");

  a_miss_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_MISS)) |-> (mac_out_o == MAC_BCAST))
    else $error("miss without broadcast MAC");

  a_learn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == ST_INSERTED) || (status_o == ST_FULL)))
      |-> (mac_out_o == '0))
    else $error("learn result with nonzero MAC");

endmodule

bind address_learning_table alt_checker u_alt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .mac_out_o (mac_out_o),
  .status_o  (status_o)
);
